/* rtl/core/eqrs_pkg.sv */
// ----------------------------------------------------------------------------
// eqrs_pkg: shared types and helpers for the ECG QRS pre-processing chain
// Holds the word formats that travel between the front end, the back end and
// the queues, and the truncating power-of-two divisions used by both ends.
// ----------------------------------------------------------------------------
package eqrs_pkg;

	localparam int DATA_W          = 32;
	localparam int LP_DIV_SHIFT    = 5;
	localparam int SLOPE_DIV_SHIFT = 3;

	typedef logic [DATA_W-1:0] data_t;

	// Word handed from the front end to the back end.
	typedef struct packed {
		data_t lowpass;
		data_t highpass;
	} mid_word_t;

	// Result word, one per accepted sample.
	typedef struct packed {
		data_t lowpass_out;
		data_t highpass_out;
		data_t slope_out;
		data_t squared_out;
		data_t window_avg_out;
	} out_word_t;

	// Signed divide by 32, rounding toward zero: bias negative values first.
	function automatic data_t div32_trunc(input data_t v);
		data_t b;
		b = v + {{(DATA_W-LP_DIV_SHIFT){1'b0}}, {LP_DIV_SHIFT{v[DATA_W-1]}}};
		return {{LP_DIV_SHIFT{b[DATA_W-1]}}, b[DATA_W-1:LP_DIV_SHIFT]};
	endfunction

	// Signed divide by 8, rounding toward zero.
	function automatic data_t div8_trunc(input data_t v);
		data_t b;
		b = v + {{(DATA_W-SLOPE_DIV_SHIFT){1'b0}}, {SLOPE_DIV_SHIFT{v[DATA_W-1]}}};
		return {{SLOPE_DIV_SHIFT{b[DATA_W-1]}}, b[DATA_W-1:SLOPE_DIV_SHIFT]};
	endfunction

endpackage

/* rtl/core/eqrs_ram.sv */
// ----------------------------------------------------------------------------
// eqrs_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module eqrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 30
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/eqrs_fifo.sv */
// ----------------------------------------------------------------------------
// eqrs_fifo: small register-based queue
// Full and empty come straight from the fill count register.
// ----------------------------------------------------------------------------
module eqrs_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

/* rtl/core/eqrs_front.sv */
// ----------------------------------------------------------------------------
// eqrs_front: sample intake, low-pass and high-pass filters
// A five-stage lockstep pipeline that stalls only when the middle queue is
// full and its last stage holds a word.
// ----------------------------------------------------------------------------
module eqrs_front #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          mid_full,
	output logic                          mid_push,
	output eqrs_pkg::mid_word_t           mid_word
);

	localparam int LP_TAPS = 12;
	localparam int LP_X6   = 5;
	localparam int LP_X12  = 11;
	localparam int HP_TAPS = 32;
	localparam int HP_X16  = 15;
	localparam int HP_X17  = 16;
	localparam int HP_X32  = 31;
	localparam int STAGES  = 5;

	logic                          adv;
	logic                          acc;
	logic [STAGES-1:0]             vld_q;
	logic signed [SAMPLE_BITS-1:0] xd_q [LP_TAPS];
	eqrs_pkg::data_t               hx_q [HP_TAPS];
	eqrs_pkg::data_t               lp1_q;
	eqrs_pkg::data_t               lp2_q;
	eqrs_pkg::data_t               hp_q;
	eqrs_pkg::data_t               x_ext;
	eqrs_pkg::data_t               x6_ext;
	eqrs_pkg::data_t               x12_ext;
	eqrs_pkg::data_t               lp_next;
	eqrs_pkg::data_t               hp_next;
	eqrs_pkg::data_t               t_s1;
	eqrs_pkg::data_t               q_s2;
	eqrs_pkg::data_t               a_s4;
	eqrs_pkg::data_t               p_s4;
	eqrs_pkg::data_t               r_s4;
	eqrs_pkg::data_t               lp_s4;
	eqrs_pkg::data_t               lp_s5;

	// The whole pipe moves unless the last stage is blocked.
	assign adv  = !(vld_q[STAGES-1] && mid_full);
	assign full = !adv;
	assign acc  = push && adv;

	assign x_ext   = eqrs_pkg::data_t'(32'(sample));
	assign x6_ext  = eqrs_pkg::data_t'(32'(xd_q[LP_X6]));
	assign x12_ext = eqrs_pkg::data_t'(32'(xd_q[LP_X12]));

	assign lp_next = {lp1_q[30:0], 1'b0} - lp2_q + q_s2;
	assign hp_next = hp_q + p_s4 + r_s4 - a_s4;

	// Filter state: delay lines and recurrences.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			lp1_q <= '0;
			lp2_q <= '0;
			hp_q  <= '0;
			for (int i = 0; i < LP_TAPS; i++) begin
				xd_q[i] <= '0;
			end
			for (int i = 0; i < HP_TAPS; i++) begin
				hx_q[i] <= '0;
			end
		end else if (adv) begin
			vld_q <= {vld_q[STAGES-2:0], acc};
			if (acc) begin
				xd_q[0] <= sample;
				for (int i = 1; i < LP_TAPS; i++) begin
					xd_q[i] <= xd_q[i-1];
				end
			end
			if (vld_q[1]) begin
				lp1_q <= lp_next;
				lp2_q <= lp1_q;
			end
			if (vld_q[2]) begin
				hx_q[0] <= lp1_q;
				for (int i = 1; i < HP_TAPS; i++) begin
					hx_q[i] <= hx_q[i-1];
				end
			end
			if (vld_q[3]) begin
				hp_q <= hp_next;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1  <= x_ext - {x6_ext[30:0], 1'b0} + x12_ext;
			q_s2  <= eqrs_pkg::div32_trunc(t_s1);
			a_s4  <= eqrs_pkg::div32_trunc(lp1_q);
			p_s4  <= hx_q[HP_X16] - hx_q[HP_X17];
			r_s4  <= eqrs_pkg::div32_trunc(hx_q[HP_X32]);
			lp_s4 <= lp1_q;
			lp_s5 <= lp_s4;
		end
	end

	assign mid_push = vld_q[STAGES-1] && !mid_full;
	assign mid_word = '{lowpass: lp_s5, highpass: hp_q};

endmodule

/* rtl/core/eqrs_back.sv */
// ----------------------------------------------------------------------------
// eqrs_back: derivative, squaring and moving-window average
// A ten-stage lockstep pipeline fed from the middle queue. The window store
// is a RAM read one stage ahead; the average uses a reciprocal multiply.
// ----------------------------------------------------------------------------
module eqrs_back #(
	parameter int WINDOW_LENGTH = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mid_empty,
	output logic                mid_pop,
	input  eqrs_pkg::mid_word_t mid_word,
	input  logic                out_full,
	output logic                out_push,
	output eqrs_pkg::out_word_t out_word
);

	localparam int          PW     = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam int          STAGES = 10;
	localparam int          SL_TAPS = 4;
	localparam logic [31:0] WLEN   = 32'(WINDOW_LENGTH);
	// floor(2^32 / WINDOW_LENGTH), kept inside 32 bits.
	localparam logic [31:0] RECIP  = (WINDOW_LENGTH == 1) ? 32'hFFFF_FFFF :
	                                 32'(64'h1_0000_0000 / WINDOW_LENGTH);

	logic                adv;
	logic                take;
	logic [STAGES-1:0]   vld_q;
	eqrs_pkg::data_t     sx_q [SL_TAPS];
	eqrs_pkg::data_t     sum_q;
	logic [PW-1:0]       pos_q;
	logic                wrapped_q;
	logic                ram_re;
	logic                ram_we;
	eqrs_pkg::data_t     ram_rdata;
	eqrs_pkg::data_t     old_val;
	logic [63:0]         sq_full;
	logic [63:0]         prod_full;
	logic [63:0]         qw_full;

	eqrs_pkg::data_t     t_s1;
	eqrs_pkg::out_word_t pl_s1, pl_s2, pl_s3, pl_s4, pl_s5, pl_s6, pl_s7, pl_s8, pl_s9;
	eqrs_pkg::out_word_t pl_s10;
	logic                zero_s4;
	logic                byp_s4;
	eqrs_pkg::data_t     bypd_s4;
	logic [PW-1:0]       waddr_s4;
	eqrs_pkg::data_t     m_s6, m_s7, m_s8;
	logic                neg_s6, neg_s7, neg_s8, neg_s9;
	logic [63:0]         prod_s7;
	eqrs_pkg::data_t     q0_s8, qw_s8;
	eqrs_pkg::data_t     qc_s9;

	assign adv     = !(vld_q[STAGES-1] && out_full);
	assign take    = adv && !mid_empty;
	assign mid_pop = take;

	// The window entry for the item leaving stage 3 is read as it moves on.
	assign ram_re = vld_q[2] && adv;
	assign ram_we = vld_q[3] && adv;

	eqrs_ram #(
		.WIDTH(eqrs_pkg::DATA_W),
		.DEPTH(WINDOW_LENGTH)
	) u_window_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_s4),
		.wdata (pl_s4.squared_out),
		.re    (ram_re),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	// Entries not yet written since reset read as zero; a read that meets the
	// write of the same entry in the same cycle takes the new value.
	assign old_val   = zero_s4 ? '0 : (byp_s4 ? bypd_s4 : ram_rdata);
	assign sq_full   = {32'd0, pl_s2.slope_out} * {32'd0, pl_s2.slope_out};
	assign prod_full = {32'd0, m_s6} * {32'd0, RECIP};
	assign qw_full   = {32'd0, prod_s7[63:32]} * {32'd0, WLEN};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			sum_q     <= '0;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			for (int i = 0; i < SL_TAPS; i++) begin
				sx_q[i] <= '0;
			end
		end else if (adv) begin
			vld_q <= {vld_q[STAGES-2:0], take};
			if (take) begin
				sx_q[0] <= mid_word.highpass;
				for (int i = 1; i < SL_TAPS; i++) begin
					sx_q[i] <= sx_q[i-1];
				end
			end
			if (vld_q[2]) begin
				if (pos_q == PW'(WINDOW_LENGTH - 1)) begin
					pos_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (vld_q[3]) begin
				sum_q <= sum_q - old_val + pl_s4.squared_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: derivative numerator.
			t_s1  <= {mid_word.highpass[30:0], 1'b0} + sx_q[0] - sx_q[2]
			         - {sx_q[3][30:0], 1'b0};
			pl_s1 <= '{lowpass_out: mid_word.lowpass, highpass_out: mid_word.highpass,
			           default: '0};
			// Stage 2: slope.
			pl_s2 <= '{lowpass_out: pl_s1.lowpass_out, highpass_out: pl_s1.highpass_out,
			           slope_out: eqrs_pkg::div8_trunc(t_s1), default: '0};
			// Stage 3: square.
			pl_s3 <= '{lowpass_out: pl_s2.lowpass_out, highpass_out: pl_s2.highpass_out,
			           slope_out: pl_s2.slope_out, squared_out: sq_full[31:0],
			           default: '0};
			// Stage 4: window read result lines up here.
			pl_s4    <= pl_s3;
			zero_s4  <= !wrapped_q;
			byp_s4   <= vld_q[3] && (waddr_s4 == pos_q);
			bypd_s4  <= pl_s4.squared_out;
			waddr_s4 <= pos_q;
			// Stage 5: running sum is in sum_q.
			pl_s5 <= pl_s4;
			// Stage 6: magnitude of the sum.
			pl_s6  <= pl_s5;
			m_s6   <= sum_q[31] ? (~sum_q + 1'b1) : sum_q;
			neg_s6 <= sum_q[31];
			// Stage 7: reciprocal multiply.
			pl_s7   <= pl_s6;
			prod_s7 <= prod_full;
			m_s7    <= m_s6;
			neg_s7  <= neg_s6;
			// Stage 8: quotient estimate times the window length.
			pl_s8  <= pl_s7;
			q0_s8  <= prod_s7[63:32];
			qw_s8  <= qw_full[31:0];
			m_s8   <= m_s7;
			neg_s8 <= neg_s7;
			// Stage 9: the estimate is low by at most one.
			pl_s9  <= pl_s8;
			qc_s9  <= ((m_s8 - qw_s8) >= WLEN) ? q0_s8 + 1'b1 : q0_s8;
			neg_s9 <= neg_s8;
			// Stage 10: restore the sign.
			pl_s10 <= '{lowpass_out: pl_s9.lowpass_out, highpass_out: pl_s9.highpass_out,
			            slope_out: pl_s9.slope_out, squared_out: pl_s9.squared_out,
			            window_avg_out: neg_s9 ? (~qc_s9 + 1'b1) : qc_s9};
		end
	end

	assign out_push = vld_q[STAGES-1] && !out_full;
	assign out_word = pl_s10;

endmodule

/* rtl/core/ecg_qrs_preprocess_chain.sv */
// ----------------------------------------------------------------------------
// ecg_qrs_preprocess_chain: QRS pre-processing filter cascade
// Low-pass, high-pass, derivative, squaring and moving-window average of a
// signed ECG sample stream, with every stage result reported per sample.
//
//   Channel  Handshake           Payload
//   -------  ------------------  ---------------------------------------------
//   in       push / full         sample
//   out      pop / empty         lowpass_out, highpass_out, slope_out,
//                                squared_out, window_avg_out
//
// One word per cycle is taken and delivered, sustained, while nothing stalls:
// every recurrence of the cascade closes in one register stage.
// Reset clears all delay lines, the running sum and the window ring; the
// window RAM is not swept, entries not yet written since reset read as zero.
// The front end stalls only when the middle queue is full, the back end only
// when the output queue is full.
// ----------------------------------------------------------------------------
module ecg_qrs_preprocess_chain #(
	parameter int SAMPLE_BITS   = 12,
	parameter int WINDOW_LENGTH = 30,
	parameter int QUEUE_DEPTH   = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [31:0]            lowpass_out,
	output logic signed [31:0]            highpass_out,
	output logic signed [31:0]            slope_out,
	output logic signed [31:0]            squared_out,
	output logic signed [31:0]            window_avg_out
);

	// Front end to middle queue.
	logic                mid_push;
	logic                mid_full;
	eqrs_pkg::mid_word_t mid_wr_word;
	// Middle queue to back end.
	logic                mid_pop;
	logic                mid_empty;
	eqrs_pkg::mid_word_t mid_rd_word;
	// Back end to output queue.
	logic                out_push;
	logic                out_full;
	eqrs_pkg::out_word_t out_wr_word;
	eqrs_pkg::out_word_t out_head;

	// The front end takes samples and runs the two filters.
	eqrs_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.sample   (sample),
		.mid_full (mid_full),
		.mid_push (mid_push),
		.mid_word (mid_wr_word)
	);

	// A short queue decouples the two halves so each stalls on its own.
	eqrs_fifo #(
		.WIDTH($bits(eqrs_pkg::mid_word_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wr_word),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rd_word),
		.empty  (mid_empty)
	);

	// The back end finishes the slope, square and window average.
	eqrs_back #(
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.mid_word  (mid_rd_word),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_word  (out_wr_word)
	);

	// Finished words wait here, so the back end keeps going while the
	// consumer holds off.
	eqrs_fifo #(
		.WIDTH($bits(eqrs_pkg::out_word_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wr_word),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_head),
		.empty  (empty)
	);

	assign lowpass_out    = out_head.lowpass_out;
	assign highpass_out   = out_head.highpass_out;
	assign slope_out      = out_head.slope_out;
	assign squared_out    = out_head.squared_out;
	assign window_avg_out = out_head.window_avg_out;

`ifndef SYNTH
	// The front end refuses samples only because the middle queue is full.
	assert property (@(posedge clk) disable iff (!arst_n) full |-> mid_full)
		else $error("front end stalled with room in the middle queue");

	// The back end never pulls from an empty middle queue.
	assert property (@(posedge clk) disable iff (!arst_n) mid_pop |-> !mid_empty)
		else $error("back end popped an empty middle queue");

	// A word written to the output queue is visible on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) out_push |=> !empty)
		else $error("output queue empty after a write");
`endif

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ECG QRS pre-processing cascade
// Feeds signed samples through the push/full side, pops results through the
// empty/pop side and compares all five stage outputs against a cycle-free
// model of the low-pass, high-pass, slope, squaring and window-average chain.
// ----------------------------------------------------------------------------
module tb;

	localparam int SAMPLE_BITS   = 12;
	localparam int WINDOW_LENGTH = 30;
	localparam int SAMPLE_MAX    = 2047;
	localparam int SAMPLE_MIN    = -2048;

	// Waveform families for the random bursts.
	typedef enum int {
		SHAPE_NOISE,
		SHAPE_WANDER,
		SHAPE_SQUARE,
		SHAPE_BEATS
	} burst_shape_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          push   = 1'b0;
	logic                          full;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic                          empty;
	logic                          pop    = 1'b0;
	logic signed [31:0]            lowpass_out;
	logic signed [31:0]            highpass_out;
	logic signed [31:0]            slope_out;
	logic signed [31:0]            squared_out;
	logic signed [31:0]            window_avg_out;

	// Samples waiting to be offered, and the result words still owed by the block.
	logic signed [SAMPLE_BITS-1:0] pending_samples[$];
	eqrs_pkg::out_word_t           expected_words[$];

	// Set by the sequencer, read by the two driving processes.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_len       = 0;
	bit hold_req       = 1'b0;

	// Owned by the output driver.
	bit hold_seen = 1'b0;
	int hold_cnt  = 0;

	// Owned by the monitor.
	bit in_taken   = 1'b0;
	int mismatches = 0;

	// Model state of the cascade; every delay line starts at zero.
	int lp_hist[12];
	int lp_prev[2];
	int hp_hist[32];
	int hp_prev;
	int slope_hist[4];
	int window_vals[WINDOW_LENGTH];
	int window_total;
	int window_slot;

	ecg_qrs_preprocess_chain #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.sample        (sample),
		.empty         (empty),
		.pop           (pop),
		.lowpass_out   (lowpass_out),
		.highpass_out  (highpass_out),
		.slope_out     (slope_out),
		.squared_out   (squared_out),
		.window_avg_out(window_avg_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Advance the cascade model by one sample and return all five stage outputs.
	// The model works in int, so sums and products wrap at 32 bits and the
	// divisions truncate toward zero, exactly like the hardware is meant to.
	function automatic eqrs_pkg::out_word_t predict_cascade(
		input logic signed [SAMPLE_BITS-1:0] s
	);
		eqrs_pkg::out_word_t w;
		int x, t, lp, hp, sl, sq, i;
		x = s;

		// Low-pass: double integrator over the trimmed FIR term.
		t  = x - 2 * lp_hist[5] + lp_hist[11];
		lp = 2 * lp_prev[0] - lp_prev[1] + t / 32;
		for (i = 11; i > 0; i--) lp_hist[i] = lp_hist[i-1];
		lp_hist[0] = x;
		lp_prev[1] = lp_prev[0];
		lp_prev[0] = lp;

		// High-pass: all-pass delay minus the scaled running low-pass.
		hp = hp_prev - lp / 32 + hp_hist[15] - hp_hist[16] + hp_hist[31] / 32;
		for (i = 31; i > 0; i--) hp_hist[i] = hp_hist[i-1];
		hp_hist[0] = lp;
		hp_prev    = hp;

		// Five-point slope.
		t  = 2 * hp + slope_hist[0] - slope_hist[2] - 2 * slope_hist[3];
		sl = t / 8;
		for (i = 3; i > 0; i--) slope_hist[i] = slope_hist[i-1];
		slope_hist[0] = hp;

		sq = sl * sl;

		// Moving window kept as a running sum over a ring of squared values.
		window_total             = window_total - window_vals[window_slot] + sq;
		window_vals[window_slot] = sq;
		window_slot = (window_slot + 1 >= WINDOW_LENGTH) ? 0 : window_slot + 1;

		w.lowpass_out    = lp;
		w.highpass_out   = hp;
		w.slope_out      = sl;
		w.squared_out    = sq;
		w.window_avg_out = window_total / WINDOW_LENGTH;
		return w;
	endfunction

	task automatic check_field(input string field, input eqrs_pkg::data_t want,
			input eqrs_pkg::data_t got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", field, $signed(want), $signed(got));
			mismatches++;
		end
	endtask

	// Append a burst of samples of one randomly chosen shape. Half of the bursts
	// look like real traces (slow wander, beats on a quiet baseline); the other half
	// are full-scale noise and rail-to-rail square waves that drive the wide stages
	// into wrap-around.
	task automatic queue_burst(input int count);
		burst_shape_t shape;
		int level, period, spike, k;
		shape  = burst_shape_t'($urandom_range(0, 3));
		level  = int'($urandom_range(0, 4095)) + SAMPLE_MIN;
		period = $urandom_range(2, 24);
		spike  = $urandom_range(200, 2047);
		for (k = 0; k < count; k++) begin
			case (shape)
				SHAPE_NOISE: begin
					level = int'($urandom_range(0, 4095)) + SAMPLE_MIN;
				end
				SHAPE_WANDER: begin
					level = level + int'($urandom_range(0, 64)) - 32;
				end
				SHAPE_SQUARE: begin
					level = (k % period < (period + 1) / 2) ? SAMPLE_MAX : SAMPLE_MIN;
				end
				default: begin
					// A short QRS-like spike every 8 to 96 samples.
					if (k % (period * 4) < 3) begin
						level = (k % (period * 4) == 1) ? spike : -spike / 4;
					end else begin
						level = int'($urandom_range(0, 40)) - 20;
					end
				end
			endcase
			if (level > SAMPLE_MAX) level = SAMPLE_MAX;
			if (level < SAMPLE_MIN) level = SAMPLE_MIN;
			pending_samples.push_back(level[SAMPLE_BITS-1:0]);
		end
	endtask

	// Input driver: changes push and sample on the falling edge. A word that
	// was offered but not taken at the last rising edge stays on the ports.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !in_taken) begin
			push <= 1'b1;
		end else if (pending_samples.size() != 0 &&
				$urandom_range(0, 99) >= send_idle_pct) begin
			push   <= 1'b1;
			sample <= pending_samples.pop_front();
		end else begin
			push <= 1'b0;
		end
	end

	// Output driver: random pop stalls, plus a long hold-off when the sequencer
	// asks for one. The hold-off is counted here, in clock cycles.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt  <= hold_len;
			pop       <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			pop      <= 1'b0;
		end else begin
			pop <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: on each rising edge, turn an accepted sample into an expected
	// word and compare an accepted result with the oldest expected word.
	always @(posedge clk) begin
		eqrs_pkg::out_word_t want;
		in_taken <= push && !full;
		if (arst_n) begin
			if (push && !full) begin
				expected_words.push_back(predict_cascade(sample));
			end
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$error("result word popped with nothing expected: lowpass_out %0d",
						lowpass_out);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					check_field("lowpass_out", want.lowpass_out, lowpass_out);
					check_field("highpass_out", want.highpass_out, highpass_out);
					check_field("slope_out", want.slope_out, slope_out);
					check_field("squared_out", want.squared_out, squared_out);
					check_field("window_avg_out", want.window_avg_out, window_avg_out);
				end
			end
		end
	end

	// Sequencer: reset, a directed opening, then random bursts under each
	// idling pattern, then a phase where the output side is held off for a
	// long stretch so that the block backs up and raises full.
	initial begin
		int phase, queued, k;
		int sender_pct[4];
		int receiver_pct[4];
		sender_pct   = '{0, 68, 0, 37};
		receiver_pct = '{0, 0, 68, 37};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: small values right after reset, each rail held for six
		// samples, and rail-to-rail toggling.
		pending_samples.push_back(SAMPLE_BITS'(0));
		pending_samples.push_back(SAMPLE_BITS'(1));
		pending_samples.push_back(SAMPLE_BITS'(-1));
		for (k = 0; k < 6; k++) pending_samples.push_back(SAMPLE_BITS'(SAMPLE_MAX));
		for (k = 0; k < 6; k++) pending_samples.push_back(SAMPLE_BITS'(SAMPLE_MIN));
		for (k = 0; k < 6; k++) begin
			pending_samples.push_back(SAMPLE_BITS'((k % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN));
		end
		pending_samples.push_back(SAMPLE_BITS'(0));
		pending_samples.push_back(SAMPLE_BITS'(0));

		for (phase = 0; phase < 4; phase++) begin
			while (pending_samples.size() != 0 || push) @(posedge clk);
			send_idle_pct  = sender_pct[phase];
			recv_stall_pct = receiver_pct[phase];
			queued = 0;
			while (queued < 60) begin
				k = $urandom_range(20, 50);
				queue_burst(k);
				queued += k;
			end
		end

		// Back-pressure: the sender keeps offering while pop is held low.
		while (pending_samples.size() != 0 || push) @(posedge clk);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_len       = 150;
		hold_req       = ~hold_req;
		queue_burst(40);
		queue_burst(40);

		// Drain everything, then give stray words time to show up.
		while (pending_samples.size() != 0 || push || expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#400000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
